// ===== sv/pmu_pkg.sv =====
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared widths, types, register codes and helpers of the particle motion
// update pipeline.
// ----------------------------------------------------------------------------
package pmu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 32;
    localparam int DT_W      = 20;
    localparam int SPD_W     = 32;
    localparam int AGE_W     = 32;
    localparam int DIFF_W    = POS_W + 1;
    localparam int MAG_W     = POS_W;
    localparam int SUM_W     = 2 * MAG_W;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int PRD_W     = SPD_W + DT_W;
    localparam int STEP_W    = PRD_W - FRAC_BITS;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIV_W     = MAG_W + FRAC_BITS;
    localparam int MUL_W     = QUO_W + STEP_W;
    localparam int MV_W      = MUL_W - FRAC_BITS;
    localparam int ACC_W     = MV_W + 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        REG_PIVOT_X = 3'd0,
        REG_PIVOT_Y = 3'd1,
        REG_PIVOT_Z = 3'd2,
        REG_LOOP_EN = 3'd3,
        REG_MODE    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pivot;
        logic                  loop_en;
        logic                  drop_mode;
    } cfg_t;

    // sideband that travels with each item down the pipeline
    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic [2:0][POS_W-1:0] base;
        logic [AGE_W-1:0]      new_age;
        logic                  restart;
        logic                  drop;
        logic [2:0]            neg;
        logic [STEP_W-1:0]     step;
    } ctx_t;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'($signed({1'b0, {(POS_W-1){1'b1}}}));
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[POS_W-1:0];
        end else if (v < lo) begin
            return lo[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ===== sv/pmu_apb.sv =====
// ----------------------------------------------------------------------------
// pmu_apb
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module pmu_apb import pmu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_PIVOT_X: cfg_reg.pivot[0] <= pwdata;
                REG_PIVOT_Y: cfg_reg.pivot[1] <= pwdata;
                REG_PIVOT_Z: cfg_reg.pivot[2] <= pwdata;
                REG_LOOP_EN: cfg_reg.loop_en  <= pwdata[0];
                REG_MODE:    cfg_reg.drop_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PIVOT_X: prdata = cfg_reg.pivot[0];
            REG_PIVOT_Y: prdata = cfg_reg.pivot[1];
            REG_PIVOT_Z: prdata = cfg_reg.pivot[2];
            REG_LOOP_EN: prdata = DATA_W'(cfg_reg.loop_en);
            REG_MODE:    prdata = DATA_W'(cfg_reg.drop_mode);
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== sv/pmu_front.sv =====
// ----------------------------------------------------------------------------
// pmu_front
// Four stages: offset from pivot, step and age; magnitudes; squares; sum.
// ----------------------------------------------------------------------------
module pmu_front import pmu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    input  logic [IDX_W-1:0]      in_index,
    input  logic [2:0][POS_W-1:0] in_pos,
    input  logic [2:0][POS_W-1:0] in_home,
    input  logic [SPD_W-1:0]      in_speed,
    input  logic [DT_W-1:0]       in_dt,
    input  logic [AGE_W-1:0]      in_age,
    input  logic [AGE_W-1:0]      in_lifetime,
    output logic                  out_valid,
    output logic [SUM_W-1:0]      out_sum,
    output logic [2:0][MAG_W-1:0] out_mag,
    output ctx_t                  out_ctx
);

    // stage 1
    logic                   v1_reg;
    logic [2:0][DIFF_W-1:0] d_reg;
    logic [PRD_W-1:0]       prd_reg;
    ctx_t                   c1_reg;
    // stage 2
    logic                   v2_reg;
    logic [2:0][MAG_W-1:0]  m2_reg;
    ctx_t                   c2_reg;
    // stage 3
    logic                   v3_reg;
    logic [2:0][SUM_W-1:0]  sq_reg;
    logic [2:0][MAG_W-1:0]  m3_reg;
    ctx_t                   c3_reg;
    // stage 4
    logic                   v4_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [2:0][MAG_W-1:0]  m4_reg;
    ctx_t                   c4_reg;

    logic [AGE_W:0]         age_sum;
    logic [AGE_W-1:0]       age_sat;
    logic                   restart;
    ctx_t                   c1_next;
    logic [2:0][DIFF_W-1:0] d_next;
    logic [2:0][DIFF_W-1:0] mag_full;
    logic [2:0]             neg;
    logic                   big;
    logic [2:0][MAG_W-1:0]  m2_next;
    ctx_t                   c2_next;

    always_comb begin
        age_sum = {1'b0, in_age} + (AGE_W+1)'(in_dt);
        age_sat = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
        restart = cfg.loop_en && (age_sat >= in_lifetime);
        c1_next = '0;
        c1_next.index   = in_index;
        c1_next.base    = restart ? in_home : in_pos;
        c1_next.new_age = restart ? '0 : age_sat;
        c1_next.restart = restart;
        c1_next.drop    = cfg.drop_mode;
        for (int i = 0; i < 3; i++) begin
            d_next[i] = {in_pos[i][POS_W-1], in_pos[i]}
                      - {cfg.pivot[i][POS_W-1], cfg.pivot[i]};
        end
    end

    always_comb begin
        big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            neg[i]      = d_reg[i][DIFF_W-1];
            mag_full[i] = neg[i] ? (~d_reg[i] + DIFF_W'(1)) : d_reg[i];
            if (mag_full[i] > (DIFF_W'(1) << (MAG_W-1))) begin
                big = 1'b1;
            end
        end
        // all axes halved together keeps the direction
        for (int i = 0; i < 3; i++) begin
            m2_next[i] = big ? mag_full[i][DIFF_W-1:1] : mag_full[i][MAG_W-1:0];
        end
        c2_next      = c1_reg;
        c2_next.neg  = neg;
        c2_next.step = prd_reg[PRD_W-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg  <= in_valid;
            d_reg   <= d_next;
            prd_reg <= PRD_W'(in_speed) * PRD_W'(in_dt);
            c1_reg  <= c1_next;

            v2_reg  <= v1_reg;
            m2_reg  <= m2_next;
            c2_reg  <= c2_next;

            v3_reg  <= v2_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SUM_W'(m2_reg[i]) * SUM_W'(m2_reg[i]);
            end
            m3_reg  <= m2_reg;
            c3_reg  <= c2_reg;

            v4_reg  <= v3_reg;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            m4_reg  <= m3_reg;
            c4_reg  <= c3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_sum   = sum_reg;
    assign out_mag   = m4_reg;
    assign out_ctx   = c4_reg;

endmodule

// ===== sv/pmu_sqrt.sv =====
// ----------------------------------------------------------------------------
// pmu_sqrt
// Pipelined integer square root, one root bit per stage, MSB first.
// ----------------------------------------------------------------------------
module pmu_sqrt import pmu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SUM_W-1:0]      in_sum,
    input  logic [2:0][MAG_W-1:0] in_mag,
    input  ctx_t                  in_ctx,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [2:0][MAG_W-1:0] out_mag,
    output ctx_t                  out_ctx
);

    wire                  vld_w  [ROOT_W+1];
    wire [SUM_W-1:0]      rem_w  [ROOT_W+1];
    wire [ROOT_W-1:0]     root_w [ROOT_W+1];
    wire [2:0][MAG_W-1:0] mag_w  [ROOT_W+1];
    wire ctx_t            ctx_w  [ROOT_W+1];

    assign vld_w[0]  = in_valid;
    assign rem_w[0]  = in_sum;
    assign root_w[0] = '0;
    assign mag_w[0]  = in_mag;
    assign ctx_w[0]  = in_ctx;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int B = ROOT_W - 1 - g;

        logic                  vld_reg;
        logic [SUM_W-1:0]      rem_reg;
        logic [ROOT_W-1:0]     root_reg;
        logic [2:0][MAG_W-1:0] mag_reg;
        ctx_t                  ctx_reg;
        logic [SUM_W+1:0]      trial;
        logic                  fits;

        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial = ((SUM_W+2)'(root_w[g]) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
        assign fits  = (SUM_W+2)'(rem_w[g]) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg  <= vld_w[g];
                rem_reg  <= fits ? rem_w[g] - trial[SUM_W-1:0] : rem_w[g];
                root_reg <= fits ? (root_w[g] | (ROOT_W'(1) << B)) : root_w[g];
                mag_reg  <= mag_w[g];
                ctx_reg  <= ctx_w[g];
            end
        end

        assign vld_w[g+1]  = vld_reg;
        assign rem_w[g+1]  = rem_reg;
        assign root_w[g+1] = root_reg;
        assign mag_w[g+1]  = mag_reg;
        assign ctx_w[g+1]  = ctx_reg;
    end

    assign out_valid = vld_w[ROOT_W];
    assign out_root  = root_w[ROOT_W];
    assign out_mag   = mag_w[ROOT_W];
    assign out_ctx   = ctx_w[ROOT_W];

endmodule

// ===== sv/pmu_div.sv =====
// ----------------------------------------------------------------------------
// pmu_div
// Pipelined restoring divider, three axes side by side: (mag << FRAC) / len.
// One quotient bit per stage; quotient never exceeds 1.0 so QUO_W bits do.
// ----------------------------------------------------------------------------
module pmu_div import pmu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [ROOT_W-1:0]     in_len,
    input  logic [2:0][MAG_W-1:0] in_mag,
    input  ctx_t                  in_ctx,
    output logic                  out_valid,
    output logic                  out_len_zero,
    output logic [2:0][QUO_W-1:0] out_quo,
    output ctx_t                  out_ctx
);

    wire                  vld_w [QUO_W+1];
    wire [ROOT_W-1:0]     len_w [QUO_W+1];
    wire [2:0][DIV_W-1:0] rem_w [QUO_W+1];
    wire [2:0][QUO_W-1:0] quo_w [QUO_W+1];
    wire ctx_t            ctx_w [QUO_W+1];

    assign vld_w[0] = in_valid;
    assign len_w[0] = in_len;
    assign quo_w[0] = '0;
    assign ctx_w[0] = in_ctx;
    for (genvar a = 0; a < 3; a++) begin : g_init
        assign rem_w[0][a] = {in_mag[a], {FRAC_BITS{1'b0}}};
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int K = QUO_W - 1 - g;

        logic                  vld_reg;
        logic [ROOT_W-1:0]     len_reg;
        logic [2:0][DIV_W-1:0] rem_reg;
        logic [2:0][QUO_W-1:0] quo_reg;
        ctx_t                  ctx_reg;
        logic [DIV_W-1:0]      dvs;
        logic [2:0][DIV_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] quo_next;

        assign dvs = DIV_W'(len_w[g]) << K;

        always_comb begin
            for (int a = 0; a < 3; a++) begin
                if (rem_w[g][a] >= dvs) begin
                    rem_next[a] = rem_w[g][a] - dvs;
                    quo_next[a] = quo_w[g][a] | (QUO_W'(1) << K);
                end else begin
                    rem_next[a] = rem_w[g][a];
                    quo_next[a] = quo_w[g][a];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_w[g];
                len_reg <= len_w[g];
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                ctx_reg <= ctx_w[g];
            end
        end

        assign vld_w[g+1] = vld_reg;
        assign len_w[g+1] = len_reg;
        assign rem_w[g+1] = rem_reg;
        assign quo_w[g+1] = quo_reg;
        assign ctx_w[g+1] = ctx_reg;
    end

    assign out_valid    = vld_w[QUO_W];
    assign out_len_zero = (len_w[QUO_W] == '0);
    assign out_quo      = quo_w[QUO_W];
    assign out_ctx      = ctx_w[QUO_W];

endmodule

// ===== sv/pmu_back.sv =====
// ----------------------------------------------------------------------------
// pmu_back
// Restart to home, drop y by step, else add step * unit vector; sat; register.
// ----------------------------------------------------------------------------
module pmu_back import pmu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  in_len_zero,
    input  logic [2:0][QUO_W-1:0] in_quo,
    input  ctx_t                  in_ctx,
    output logic                  out_valid,
    output logic [IDX_W-1:0]      out_index,
    output logic [2:0][POS_W-1:0] out_pos,
    output logic [AGE_W-1:0]      out_age,
    output logic                  out_restarted
);

    logic                  v1_reg;
    logic                  lz_reg;
    logic [2:0][MUL_W-1:0] mul_reg;
    ctx_t                  c1_reg;

    logic                  v2_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [2:0][POS_W-1:0] pos_reg;
    logic [AGE_W-1:0]      age_reg;
    logic                  rst_reg;

    logic [2:0][POS_W-1:0] pos_next;
    logic [MV_W-1:0]       mv;
    logic signed [ACC_W-1:0] acc;

    always_comb begin
        pos_next = c1_reg.base;
        mv       = '0;
        acc      = '0;
        if (c1_reg.restart) begin
            pos_next = c1_reg.base;
        end else if (c1_reg.drop) begin
            acc = ACC_W'($signed(c1_reg.base[1])) - $signed(ACC_W'(c1_reg.step));
            pos_next[1] = sat_pos(acc);
        end else if (!lz_reg) begin
            for (int i = 0; i < 3; i++) begin
                mv  = mul_reg[i][MUL_W-1:FRAC_BITS];
                acc = c1_reg.neg[i] ? -$signed(ACC_W'(mv)) : $signed(ACC_W'(mv));
                acc = acc + ACC_W'($signed(c1_reg.base[i]));
                pos_next[i] = sat_pos(acc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            lz_reg <= in_len_zero;
            c1_reg <= in_ctx;
            for (int i = 0; i < 3; i++) begin
                mul_reg[i] <= MUL_W'(in_quo[i]) * MUL_W'(in_ctx.step);
            end

            v2_reg  <= v1_reg;
            idx_reg <= c1_reg.index;
            pos_reg <= pos_next;
            age_reg <= c1_reg.new_age;
            rst_reg <= c1_reg.restart;
        end
    end

    assign out_valid     = v2_reg;
    assign out_index     = idx_reg;
    assign out_pos       = pos_reg;
    assign out_age       = age_reg;
    assign out_restarted = rst_reg;

endmodule

// ===== sv/particle_motion_update.sv =====
// ----------------------------------------------------------------------------
// particle_motion_update
// Euler position/age update of one particle record per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one particle record per transfer (valid/ready), m_* returns
//   the updated record, in order, one per input transfer.
//   The APB port holds pivot, loop enable and mode; write it only while the
//   pipeline is empty. pready is tied high, reads return the stored value.
// Pipeline: 55 register stages: 4 front stages, 32 square-root stages
//   (one root bit each), 17 divider stages (one quotient bit each), a
//   multiply stage and the output register.
// Throughput: one record per cycle unless stalled. The whole pipeline
//   advances together whenever the output register is empty or being taken.
// Stall: when m_valid is high and m_ready low, every stage holds and s_ready
//   drops; nothing is lost or repeated.
// Reset: synchronous, active low; clears all stage valids and the registers
//   (pivot 0, looping off, spread mode).
// ----------------------------------------------------------------------------
module particle_motion_update import pmu_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [IDX_W-1:0]         s_particle_index,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic signed [POS_W-1:0]  s_home_x,
    input  logic signed [POS_W-1:0]  s_home_y,
    input  logic signed [POS_W-1:0]  s_home_z,
    input  logic [SPD_W-1:0]         s_speed,
    input  logic [DT_W-1:0]          s_dt,
    input  logic [AGE_W-1:0]         s_age,
    input  logic [AGE_W-1:0]         s_lifetime,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_W-1:0]         m_out_index,
    output logic signed [POS_W-1:0]  m_new_pos_x,
    output logic signed [POS_W-1:0]  m_new_pos_y,
    output logic signed [POS_W-1:0]  m_new_pos_z,
    output logic [AGE_W-1:0]         m_new_age,
    output logic                     m_restarted
);

    cfg_t                  cfg;
    logic                  adv;
    logic [2:0][POS_W-1:0] pos_in;
    logic [2:0][POS_W-1:0] home_in;

    logic                  f_valid;
    logic [SUM_W-1:0]      f_sum;
    logic [2:0][MAG_W-1:0] f_mag;
    ctx_t                  f_ctx;

    logic                  r_valid;
    logic [ROOT_W-1:0]     r_root;
    logic [2:0][MAG_W-1:0] r_mag;
    ctx_t                  r_ctx;

    logic                  d_valid;
    logic                  d_len_zero;
    logic [2:0][QUO_W-1:0] d_quo;
    ctx_t                  d_ctx;

    logic [2:0][POS_W-1:0] pos_out;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign pos_in  = {s_pos_z, s_pos_y, s_pos_x};
    assign home_in = {s_home_z, s_home_y, s_home_x};

    pmu_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .cfg         (cfg),
        .in_valid    (s_valid),
        .in_index    (s_particle_index),
        .in_pos      (pos_in),
        .in_home     (home_in),
        .in_speed    (s_speed),
        .in_dt       (s_dt),
        .in_age      (s_age),
        .in_lifetime (s_lifetime),
        .out_valid   (f_valid),
        .out_sum     (f_sum),
        .out_mag     (f_mag),
        .out_ctx     (f_ctx)
    );

    pmu_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (f_valid),
        .in_sum    (f_sum),
        .in_mag    (f_mag),
        .in_ctx    (f_ctx),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_mag   (r_mag),
        .out_ctx   (r_ctx)
    );

    pmu_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (r_valid),
        .in_len       (r_root),
        .in_mag       (r_mag),
        .in_ctx       (r_ctx),
        .out_valid    (d_valid),
        .out_len_zero (d_len_zero),
        .out_quo      (d_quo),
        .out_ctx      (d_ctx)
    );

    pmu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (d_valid),
        .in_len_zero   (d_len_zero),
        .in_quo        (d_quo),
        .in_ctx        (d_ctx),
        .out_valid     (m_valid),
        .out_index     (m_out_index),
        .out_pos       (pos_out),
        .out_age       (m_new_age),
        .out_restarted (m_restarted)
    );

    assign m_new_pos_x = pos_out[0];
    assign m_new_pos_y = pos_out[1];
    assign m_new_pos_z = pos_out[2];

endmodule

// ===== sv/pmu_checker.sv =====
// ----------------------------------------------------------------------------
// pmu_checker
// Port-level checks of the particle motion update block, bound to the top.
// ----------------------------------------------------------------------------
module pmu_checker import pmu_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    pready,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [POS_W-1:0] m_new_pos_x,
    input logic [AGE_W-1:0]        m_new_age,
    input logic                    m_restarted
);

    // held result (valid and x position) stays put until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_pos_x))
        else $error("result changed while stalled");

    // input side only stalls because the output is stalled
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    a_restart_age: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_restarted |-> m_new_age == '0)
        else $error("restarted particle with nonzero age");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind particle_motion_update pmu_checker u_pmu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .pready      (pready),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_new_pos_x (m_new_pos_x),
    .m_new_age   (m_new_age),
    .m_restarted (m_restarted)
);
